### rtl/jcb_pkg.sv
// ----------------------------------------------------------------------------
// jcb_pkg: shared types and constants of the comment blanker
// Character codes, scan modes, queue entry layout and queue status.
// ----------------------------------------------------------------------------
package jcb_pkg;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Queue between the front and back parts
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_STRING = 4'b0010,
        MODE_LINE   = 4'b0100,
        MODE_BLOCK  = 4'b1000
    } mode_t;

    // One classified input item: one or two cleaned bytes
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic       two;
        logic       last;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### rtl/json_comment_blanker.sv
// ----------------------------------------------------------------------------
// json_comment_blanker: streaming JSONC comment blanker
// Blanks // # and /* */ comments to spaces, keeps newlines and strings.
// ----------------------------------------------------------------------------
//
//  channel  | handshake      | fields
//  ---------+----------------+---------------------------
//  input    | push / full    | in_byte[7:0], in_last
//  result   | empty / pop    | out_byte[7:0], out_last
//
//  An input byte is classified in the cycle it is accepted, and the entry it
//  makes, if any, is written to the queue at that edge; the back moves entries
//  from the queue into the output register, where each byte waits for pop.
//  While the queue holds entries and pop keeps up, the output register gives
//  one byte per cycle, so items that expand to two bytes (opening or closing
//  delimiters, a released held byte followed by a byte, and a flushed held
//  byte) give two output bytes; the four-entry queue absorbs those. Reset
//  puts the scanner in normal text with nothing held and empties the queue
//  and output register. A stalled pop only backs up the queue; full rises when all four entries wait.
//
module json_comment_blanker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       out_last
);

    jcb_pkg::q_stat_t q_stat;
    jcb_pkg::entry_t  q_wr_entry;
    jcb_pkg::entry_t  q_head;
    logic             q_push;
    logic             q_pop;

    // Front: classify each byte, hold lookahead, emit up to two bytes
    jcb_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_byte (in_byte),
        .in_last (in_last),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_entry (q_wr_entry)
    );

    // Queue: decouple classification from output pacing
    jcb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_push),
        .wr_entry (q_wr_entry),
        .rd       (q_pop),
        .rd_entry (q_head),
        .stat     (q_stat)
    );

    // Back: serialize entries into the output register
    jcb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .out_last (out_last)
    );

endmodule

### rtl/jcb_front.sv
// ----------------------------------------------------------------------------
// jcb_front: byte classifier
// Tracks the scan mode, escape parity and the held lookahead byte, and turns
// each accepted byte into at most one queue entry of up to two cleaned bytes.
// ----------------------------------------------------------------------------
module jcb_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  jcb_pkg::q_stat_t q_stat,
    output logic             q_push,
    output jcb_pkg::entry_t  q_entry
);

    jcb_pkg::mode_t mode_reg, mode_next;
    logic           esc_reg, esc_next;
    logic           held_reg, held_next;
    logic [1:0]     n;
    logic [7:0]     e0, e1;
    logic           done;
    logic           accept;

    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        held_next = held_reg;
        n         = 2'd0;
        e0        = jcb_pkg::CH_SPACE;
        e1        = jcb_pkg::CH_SPACE;
        done      = 1'b0;

        // Resolve the held byte first
        if (held_reg)
        begin
            held_next = 1'b0;
            if (mode_reg == jcb_pkg::MODE_NORMAL)
            begin
                if (in_byte == jcb_pkg::CH_SLASH || in_byte == jcb_pkg::CH_STAR)
                begin
                    mode_next = (in_byte == jcb_pkg::CH_SLASH) ? jcb_pkg::MODE_LINE
                                                               : jcb_pkg::MODE_BLOCK;
                    n    = 2'd2;
                    done = 1'b1;
                end
                else
                begin
                    e0 = jcb_pkg::CH_SLASH;
                    n  = 2'd1;
                end
            end
            else
            begin
                if (in_byte == jcb_pkg::CH_SLASH)
                begin
                    mode_next = jcb_pkg::MODE_NORMAL;
                    n    = 2'd2;
                    done = 1'b1;
                end
                else
                begin
                    n = 2'd1;
                end
            end
        end

        // Handle the byte itself; at most one byte goes out here
        if (!done)
        begin
            unique case (mode_reg)
                jcb_pkg::MODE_NORMAL:
                begin
                    if (in_byte == jcb_pkg::CH_SLASH)
                    begin
                        held_next = 1'b1;
                    end
                    else
                    begin
                        if (n == 2'd0) e0 = (in_byte == jcb_pkg::CH_HASH) ? jcb_pkg::CH_SPACE
                                                                            : in_byte;
                        else           e1 = (in_byte == jcb_pkg::CH_HASH) ? jcb_pkg::CH_SPACE
                                                                            : in_byte;
                        n = n + 2'd1;
                        if (in_byte == jcb_pkg::CH_QUOTE)
                        begin
                            mode_next = jcb_pkg::MODE_STRING;
                            esc_next  = 1'b0;
                        end
                        else if (in_byte == jcb_pkg::CH_HASH)
                        begin
                            mode_next = jcb_pkg::MODE_LINE;
                        end
                    end
                end
                jcb_pkg::MODE_STRING:
                begin
                    if (in_byte == jcb_pkg::CH_QUOTE && !esc_reg)
                        mode_next = jcb_pkg::MODE_NORMAL;
                    esc_next = (in_byte == jcb_pkg::CH_BSLASH) ? !esc_reg : 1'b0;
                    e0 = in_byte;
                    n  = 2'd1;
                end
                jcb_pkg::MODE_LINE:
                begin
                    if (in_byte == jcb_pkg::CH_NL)
                    begin
                        mode_next = jcb_pkg::MODE_NORMAL;
                        e0 = jcb_pkg::CH_NL;
                    end
                    n = 2'd1;
                end
                jcb_pkg::MODE_BLOCK:
                begin
                    if (in_byte == jcb_pkg::CH_STAR)
                    begin
                        held_next = 1'b1;
                    end
                    else
                    begin
                        if (n == 2'd0)
                            e0 = (in_byte == jcb_pkg::CH_NL) ? jcb_pkg::CH_NL
                                                             : jcb_pkg::CH_SPACE;
                        else
                            e1 = (in_byte == jcb_pkg::CH_NL) ? jcb_pkg::CH_NL
                                                             : jcb_pkg::CH_SPACE;
                        n = n + 2'd1;
                    end
                end
                default:
                begin
                    n = n;
                end
            endcase
        end

        // End of text: flush the held byte and drop back to reset state
        if (in_last)
        begin
            if (held_next)
            begin
                if (n == 2'd0)
                    e0 = (mode_next == jcb_pkg::MODE_BLOCK) ? jcb_pkg::CH_SPACE
                                                            : jcb_pkg::CH_SLASH;
                else
                    e1 = (mode_next == jcb_pkg::MODE_BLOCK) ? jcb_pkg::CH_SPACE
                                                            : jcb_pkg::CH_SLASH;
                n = n + 2'd1;
            end
            mode_next = jcb_pkg::MODE_NORMAL;
            esc_next  = 1'b0;
            held_next = 1'b0;
        end
    end

    assign q_push        = accept && (n != 2'd0);
    assign q_entry.b0    = e0;
    assign q_entry.b1    = e1;
    assign q_entry.two   = n[1];
    assign q_entry.last  = in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= jcb_pkg::MODE_NORMAL;
            esc_reg  <= 1'b0;
            held_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            held_reg <= held_next;
        end
    end

    a_held_mode: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> (mode_reg == jcb_pkg::MODE_NORMAL || mode_reg == jcb_pkg::MODE_BLOCK))
        else $error("held byte outside normal text or block comment");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

endmodule

### rtl/jcb_queue.sv
// ----------------------------------------------------------------------------
// jcb_queue: entry queue between classifier and output stage
// Small register queue; lets the front keep taking bytes while the back
// drains two-byte entries.
// ----------------------------------------------------------------------------
module jcb_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  jcb_pkg::entry_t  wr_entry,
    input  logic             rd,
    output jcb_pkg::entry_t  rd_entry,
    output jcb_pkg::q_stat_t stat
);

    jcb_pkg::entry_t                 mem [jcb_pkg::QDEPTH];
    logic [jcb_pkg::QAW-1:0]         wr_ptr_reg;
    logic [jcb_pkg::QAW-1:0]         rd_ptr_reg;
    logic [jcb_pkg::QCW-1:0]         count_reg, count_next;
    logic                            do_wr, do_rd;

    assign stat.full  = (count_reg == jcb_pkg::QCW'(jcb_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign rd_entry   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= jcb_pkg::QCW'(jcb_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != jcb_pkg::QCW'(jcb_pkg::QDEPTH)) |->
            (jcb_pkg::QAW'(wr_ptr_reg - rd_ptr_reg) == count_reg[jcb_pkg::QAW-1:0]))
        else $error("queue pointers disagree with count");

endmodule

### rtl/jcb_back.sv
// ----------------------------------------------------------------------------
// jcb_back: output stage
// Splits queue entries into single bytes and holds each in an output
// register until it is popped.
// ----------------------------------------------------------------------------
module jcb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  jcb_pkg::q_stat_t q_stat,
    input  jcb_pkg::entry_t  q_head,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       out_byte,
    output logic             out_last
);

    logic       valid_reg;
    logic       phase_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;
    logic       final_part;

    assign empty      = !valid_reg;
    assign out_byte   = byte_reg;
    assign out_last   = last_reg;
    assign load       = !q_stat.empty && (!valid_reg || pop);
    assign final_part = phase_reg || !q_head.two;
    assign q_pop      = load && final_part;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= phase_reg ? q_head.b1 : q_head.b0;
            last_reg <= q_head.last && final_part;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (load)
                valid_reg <= 1'b1;
            else if (pop)
                valid_reg <= 1'b0;
            if (load)
                phase_reg <= !final_part;
        end
    end

    a_phase_two: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (!q_stat.empty && q_head.two))
        else $error("second byte pending without a two-byte entry");

endmodule
